// ===== hw/rtl/kcl_pkg.sv =====
// Shared types and constants of the keypad code lock.
package kcl_pkg;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 4;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int BUZZ_W   = 2;
  localparam int ID_W     = 10;
  localparam int CODE_W   = 13;
  localparam int CFG_IDX_W = 3;

  // Number of user ID registers on the configuration port
  localparam int ID_REGS = 5;
  // Keys per ID or code entry
  localparam int CODE_DIGITS = 3;
  // Largest slot count the reset tables cover
  localparam int MAX_SLOTS = 8;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_KEY    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADMIN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHANGE = 2'd2;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRONG_ID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG_CODE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOOR_OPEN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_STORED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CONTACT    = 3'd6;

  // Reset contents per slot; slots past the fifth start at zero
  localparam logic [ID_W-1:0] ID_RESET [MAX_SLOTS] = '{
    10'd111, 10'd126, 10'd128, 10'd130, 10'd132, 10'd0, 10'd0, 10'd0
  };
  localparam logic [CODE_W-1:0] CODE_RESET [MAX_SLOTS] = '{
    13'd203, 13'd129, 13'd325, 13'd426, 13'd79, 13'd0, 13'd0, 13'd0
  };

  // One key request
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key_code;
  } kcl_req_t;

  // One result
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   user_slot;
    logic [BUZZ_W-1:0]   buzz_count;
    logic                door_open;
  } kcl_res_t;

endpackage

// ===== hw/rtl/kcl_if.sv =====
// Valid/ready channel interfaces for key requests and lock results.
interface kcl_in_if;
  import kcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key_code;
  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

interface kcl_out_if;
  import kcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   user_slot;
  logic [BUZZ_W-1:0]   buzz_count;
  logic                door_open;
  modport source (output valid, output status, output user_slot, output buzz_count,
                  output door_open, input ready);
  modport sink   (input valid, input status, input user_slot, input buzz_count,
                  input door_open, output ready);
endinterface

// ===== hw/rtl/kcl_in_stage.sv =====
// Input register stage of the keypad code lock.
module kcl_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  kcl_pkg::kcl_req_t req_data,
  output logic              stg_valid,
  input  logic              stg_take,
  output kcl_pkg::kcl_req_t stg_data
);
  import kcl_pkg::*;

  logic     valid_r;
  kcl_req_t data_r;

  // Refill whenever the held request leaves or the stage is empty
  assign req_ready = !valid_r || stg_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      data_r <= req_data;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;
endmodule

// ===== hw/rtl/kcl_core.sv =====
// Lock state machine, ID/code storage and result register.
module kcl_core #(
  parameter int USER_SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::ID_W-1:0]      cfg_wdata,
  input  logic                          stg_valid,
  output logic                          stg_take,
  input  kcl_pkg::kcl_req_t             stg_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output kcl_pkg::kcl_res_t             res_data
);
  import kcl_pkg::*;

  localparam int IDX_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

  // Flow modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ACCESS = 2'd1;
  localparam logic [1:0] MODE_ADMIN  = 2'd2;
  localparam logic [1:0] MODE_CHANGE = 2'd3;

  localparam logic [CODE_W-1:0] W_HUND = 13'd100;
  localparam logic [CODE_W-1:0] W_TEN  = 13'd10;
  localparam logic [5:0] KW_STAR = 6'd42;
  localparam logic [5:0] KW_HASH = 6'd35;

  logic [1:0]        mode_r, mode_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;
  logic [CODE_W-1:0] eval_r, eval_nxt;
  logic [IDX_W-1:0]  mslot_r, mslot_nxt;
  logic [CODE_W-1:0] first_r, first_nxt;
  logic [ID_W-1:0]   id_r   [USER_SLOTS];
  logic [CODE_W-1:0] code_r [USER_SLOTS];

  logic              res_valid_r;
  kcl_res_t          res_r, res_nxt;

  logic              code_we;
  logic [5:0]        kw;
  logic [CODE_W-1:0] delta;
  logic [CODE_W-1:0] sum;
  logic              hit;
  logic [IDX_W-1:0]  hit_slot;
  logic [CODE_W-1:0] cur_code;

  // Stage advances when the result register is free or drained
  assign stg_take = !res_valid_r || res_ready;

  // Key weight and positional contribution
  always_comb begin
    priority if (stg_data.key_code == KEY_STAR) begin
      kw = KW_STAR;
    end else if (stg_data.key_code == KEY_HASH) begin
      kw = KW_HASH;
    end else begin
      kw = 6'(stg_data.key_code);
    end
    unique case (dcnt_r)
      2'd0:    delta = CODE_W'(kw) * W_HUND;
      2'd1:    delta = CODE_W'(kw) * W_TEN;
      default: delta = CODE_W'(kw);
    endcase
    sum = eval_r + delta;
  end

  // ID match, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = USER_SLOTS - 1; i >= 0; i--) begin
      if (sum == CODE_W'(id_r[i])) begin
        hit      = 1'b1;
        hit_slot = IDX_W'(i);
      end
    end
  end

  assign cur_code = code_r[mslot_r];

  // Next state and result for the held request
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    eval_nxt  = eval_r;
    mslot_nxt = mslot_r;
    first_nxt = first_r;
    code_we   = 1'b0;
    res_nxt   = '{status: ST_IGNORED, user_slot: '0, buzz_count: '0, door_open: 1'b0};

    if (stg_data.opcode != OP_KEY) begin
      if (mode_r == MODE_IDLE &&
          (stg_data.opcode == OP_ADMIN || stg_data.opcode == OP_CHANGE)) begin
        mode_nxt  = (stg_data.opcode == OP_ADMIN) ? MODE_ADMIN : MODE_CHANGE;
        phase_nxt = 2'd0;
        dcnt_nxt  = 2'd0;
        eval_nxt  = '0;
        res_nxt.status = ST_ACCEPTED;
      end
    end else if (stg_data.key_code <= KEY_HASH) begin
      if (mode_r == MODE_IDLE) begin
        if (stg_data.key_code == KEY_STAR) begin
          mode_nxt  = MODE_ACCESS;
          phase_nxt = 2'd0;
          dcnt_nxt  = 2'd0;
          eval_nxt  = '0;
          res_nxt.status = ST_ACCEPTED;
        end
      end else begin
        res_nxt.status = ST_ACCEPTED;
        if (32'(dcnt_r) + 32'd1 < 32'(CODE_DIGITS)) begin
          dcnt_nxt = dcnt_r + 2'd1;
          eval_nxt = sum;
        end else begin
          // Entry complete: sum is the entered value
          dcnt_nxt = 2'd0;
          eval_nxt = '0;
          unique case (mode_r)
            MODE_ACCESS: begin
              if (phase_r == 2'd0) begin
                if (hit) begin
                  mslot_nxt = hit_slot;
                  phase_nxt = 2'd1;
                end else begin
                  res_nxt.status     = ST_WRONG_ID;
                  res_nxt.buzz_count = 2'd2;
                  mode_nxt           = MODE_IDLE;
                  phase_nxt          = 2'd0;
                end
              end else begin
                if (sum == cur_code) begin
                  res_nxt.status    = ST_DOOR_OPEN;
                  res_nxt.user_slot = SLOT_W'(mslot_r);
                  res_nxt.door_open = 1'b1;
                end else begin
                  res_nxt.status     = ST_WRONG_CODE;
                  res_nxt.buzz_count = 2'd1;
                end
                mode_nxt  = MODE_IDLE;
                phase_nxt = 2'd0;
              end
            end
            MODE_ADMIN: begin
              unique case (phase_r)
                2'd0: begin
                  if (sum == code_r[0]) begin
                    phase_nxt = 2'd1;
                  end else begin
                    res_nxt.status     = ST_WRONG_CODE;
                    res_nxt.buzz_count = 2'd2;
                    mode_nxt           = MODE_IDLE;
                    phase_nxt          = 2'd0;
                  end
                end
                2'd1: begin
                  if (hit) begin
                    mslot_nxt = hit_slot;
                    phase_nxt = 2'd2;
                  end else begin
                    res_nxt.status     = ST_WRONG_ID;
                    res_nxt.buzz_count = 2'd2;
                    mode_nxt           = MODE_IDLE;
                    phase_nxt          = 2'd0;
                  end
                end
                2'd2: begin
                  if (sum == cur_code) begin
                    phase_nxt = 2'd3;
                  end else begin
                    res_nxt.status     = ST_CONTACT;
                    res_nxt.buzz_count = 2'd2;
                    mode_nxt           = MODE_IDLE;
                    phase_nxt          = 2'd0;
                  end
                end
                default: begin
                  code_we           = 1'b1;
                  res_nxt.status    = ST_STORED;
                  res_nxt.user_slot = SLOT_W'(mslot_r);
                  mode_nxt          = MODE_IDLE;
                  phase_nxt         = 2'd0;
                end
              endcase
            end
            default: begin
              // user change flow
              unique case (phase_r)
                2'd0: begin
                  if (hit) begin
                    mslot_nxt = hit_slot;
                    phase_nxt = 2'd1;
                  end else begin
                    res_nxt.status     = ST_WRONG_ID;
                    res_nxt.buzz_count = 2'd2;
                    mode_nxt           = MODE_IDLE;
                    phase_nxt          = 2'd0;
                  end
                end
                2'd1: begin
                  if (sum == cur_code) begin
                    phase_nxt = 2'd2;
                  end else begin
                    res_nxt.status     = ST_CONTACT;
                    res_nxt.buzz_count = 2'd2;
                    mode_nxt           = MODE_IDLE;
                    phase_nxt          = 2'd0;
                  end
                end
                2'd2: begin
                  first_nxt = sum;
                  phase_nxt = 2'd3;
                end
                default: begin
                  if (sum == first_r) begin
                    code_we           = 1'b1;
                    res_nxt.status    = ST_STORED;
                    res_nxt.user_slot = SLOT_W'(mslot_r);
                  end else begin
                    res_nxt.status     = ST_CONTACT;
                    res_nxt.buzz_count = 2'd2;
                  end
                  mode_nxt  = MODE_IDLE;
                  phase_nxt = 2'd0;
                end
              endcase
            end
          endcase
        end
      end
    end
  end

  // Flow state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= 2'd0;
      dcnt_r  <= 2'd0;
      eval_r  <= '0;
      mslot_r <= '0;
      first_r <= '0;
    end else if (stg_valid && stg_take) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      eval_r  <= eval_nxt;
      mslot_r <= mslot_nxt;
      first_r <= first_nxt;
    end
  end

  // User ID registers; only the first five slots are writable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        id_r[i] <= ID_RESET[i % MAX_SLOTS];
      end
    end else begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        if (i < ID_REGS && cfg_we && cfg_index == CFG_IDX_W'(i)) begin
          id_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Stored codes, written at the matched slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        code_r[i] <= CODE_RESET[i % MAX_SLOTS];
      end
    end else begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        if (stg_valid && stg_take && code_we && mslot_r == IDX_W'(i)) begin
          code_r[i] <= sum;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (stg_take) begin
      res_valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take && stg_valid) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;
endmodule

// ===== hw/rtl/keypad_code_lock.sv =====
// Top level of the keypad code lock: input stage, lock core, result register.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_chan  | in  | valid/ready       | opcode[1:0], key_code[3:0]
//   out_chan | out | valid/ready       | status[2:0], user_slot[2:0],
//            |     |                   | buzz_count[1:0], door_open
//   cfg      | in  | cfg_we (no ready) | cfg_index[2:0], cfg_wdata[9:0]
//
// Every request yields one result. An accepted request is held in the input
// register, then passes through the lock logic into the result register, which
// drives out_chan.valid; the result register loads only while it is empty or
// draining. One request per cycle is sustained while out_chan.ready stays high.
// Reset (rst_n low, synchronous) returns the lock to idle and reloads the
// user IDs and stored codes; no clearing pass is needed.
// A stalled result holds the result register; the input register still takes
// one more request behind it before in_chan.ready drops.
module keypad_code_lock #(
  parameter int USER_SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kcl_in_if.sink                        in_chan,
  kcl_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::ID_W-1:0]      cfg_wdata
);
  import kcl_pkg::*;

  kcl_req_t req;
  kcl_req_t stg_data;
  logic     stg_valid;
  logic     stg_take;
  kcl_res_t res;

  assign req.opcode   = in_chan.opcode;
  assign req.key_code = in_chan.key_code;

  kcl_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_chan.valid),
    .req_ready (in_chan.ready),
    .req_data  (req),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .stg_data  (stg_data)
  );

  kcl_core #(
    .USER_SLOTS (USER_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .stg_data  (stg_data),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res_data  (res)
  );

  assign out_chan.status     = res.status;
  assign out_chan.user_slot  = res.user_slot;
  assign out_chan.buzz_count = res.buzz_count;
  assign out_chan.door_open  = res.door_open;
endmodule

// ===== verif/tb_keypad_code_lock.sv =====
// Self-checking testbench for the keypad code lock: directed entry flows, then random sessions.
module tb_keypad_code_lock;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int          SLOTS      = 5;
  localparam int          ANY_KEYS   = -1;     // entry made of random keys
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef enum logic [1:0] {LOCK_IDLE, LOCK_ACCESS, LOCK_ADMIN, LOCK_CHANGE} lock_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_wdata;

  kcl_in_if  in_chan ();
  kcl_out_if out_chan ();

  keypad_code_lock #(.USER_SLOTS(SLOTS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lock state as the testbench sees it
  lock_mode_e        lk_mode;
  logic [2:0]        lk_phase;
  logic [1:0]        lk_digits;
  logic [CODE_W-1:0] lk_sum;
  logic [SLOT_W-1:0] lk_slot;
  logic [CODE_W-1:0] lk_first_code;
  logic [CODE_W-1:0] lk_codes [SLOTS];
  logic [ID_W-1:0]   lk_ids   [SLOTS];

  kcl_res_t    lock_verdicts [$];
  int unsigned requests_sent;
  int unsigned mismatches;
  int unsigned id_settings;
  int unsigned status_seen [8];
  bit          bursts_on;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned key_weight(input logic [KEY_W-1:0] key);
    if (key == KEY_STAR) return 42;
    if (key == KEY_HASH) return 35;
    return 32'(key);
  endfunction

  function automatic int unsigned place_weight(input logic [1:0] pos);
    case (pos)
      2'd0:    return 100;
      2'd1:    return 10;
      default: return 1;
    endcase
  endfunction

  function automatic void go_idle();
    lk_mode   = LOCK_IDLE;
    lk_phase  = '0;
    lk_digits = '0;
    lk_sum    = '0;
  endfunction

  function automatic void reset_lock_state();
    for (int i = 0; i < SLOTS; i++) begin
      lk_ids[i]   = ID_RESET[i % MAX_SLOTS];
      lk_codes[i] = CODE_RESET[i % MAX_SLOTS];
    end
    go_idle();
    lk_slot       = '0;
    lk_first_code = '0;
  endfunction

  // lowest matching slot wins
  function automatic bit find_user(input logic [CODE_W-1:0] val);
    for (int i = 0; i < SLOTS; i++) begin
      if (CODE_W'(lk_ids[i]) == val) begin
        lk_slot = SLOT_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic kcl_res_t predict_verdict(input logic [OPCODE_W-1:0] op,
                                               input logic [KEY_W-1:0] key);
    kcl_res_t          r;
    logic [CODE_W-1:0] val;
    r        = '0;
    r.status = ST_IGNORED;
    if (op != OP_KEY) begin
      // change requests only start from idle
      if (lk_mode == LOCK_IDLE && (op == OP_ADMIN || op == OP_CHANGE)) begin
        go_idle();
        lk_mode  = (op == OP_ADMIN) ? LOCK_ADMIN : LOCK_CHANGE;
        r.status = ST_ACCEPTED;
      end
    end else if (key <= KEY_HASH) begin
      if (lk_mode == LOCK_IDLE) begin
        if (key == KEY_STAR) begin
          go_idle();
          lk_mode  = LOCK_ACCESS;
          r.status = ST_ACCEPTED;
        end
      end else begin
        lk_sum   = CODE_W'(lk_sum + key_weight(key) * place_weight(lk_digits));
        r.status = ST_ACCEPTED;
        if (lk_digits + 1 < CODE_DIGITS) begin
          lk_digits++;
        end else begin
          val       = lk_sum;
          lk_digits = '0;
          lk_sum    = '0;
          case (lk_mode)
            LOCK_ACCESS: begin
              if (lk_phase == 0) begin
                if (find_user(val)) lk_phase = 3'd1;
                else begin
                  r.status = ST_WRONG_ID; r.buzz_count = 2'd2; go_idle();
                end
              end else begin
                if (val == lk_codes[lk_slot]) begin
                  r.status = ST_DOOR_OPEN; r.user_slot = lk_slot; r.door_open = 1'b1;
                end else begin
                  r.status = ST_WRONG_CODE; r.buzz_count = 2'd1;
                end
                go_idle();
              end
            end
            LOCK_ADMIN: begin
              if (lk_phase == 0) begin
                if (val == lk_codes[0]) lk_phase = 3'd1;
                else begin
                  r.status = ST_WRONG_CODE; r.buzz_count = 2'd2; go_idle();
                end
              end else if (lk_phase == 1) begin
                if (find_user(val)) lk_phase = 3'd2;
                else begin
                  r.status = ST_WRONG_ID; r.buzz_count = 2'd2; go_idle();
                end
              end else if (lk_phase == 2) begin
                if (val == lk_codes[lk_slot]) lk_phase = 3'd3;
                else begin
                  r.status = ST_CONTACT; r.buzz_count = 2'd2; go_idle();
                end
              end else begin
                lk_codes[lk_slot] = val;
                r.status = ST_STORED; r.user_slot = lk_slot;
                go_idle();
              end
            end
            default: begin
              // user change: id, old code, new code, new code again
              if (lk_phase == 0) begin
                if (find_user(val)) lk_phase = 3'd1;
                else begin
                  r.status = ST_WRONG_ID; r.buzz_count = 2'd2; go_idle();
                end
              end else if (lk_phase == 1) begin
                if (val == lk_codes[lk_slot]) lk_phase = 3'd2;
                else begin
                  r.status = ST_CONTACT; r.buzz_count = 2'd2; go_idle();
                end
              end else if (lk_phase == 2) begin
                lk_first_code = val;
                lk_phase      = 3'd3;
              end else begin
                if (val == lk_first_code) begin
                  lk_codes[lk_slot] = val;
                  r.status = ST_STORED; r.user_slot = lk_slot;
                end else begin
                  r.status = ST_CONTACT; r.buzz_count = 2'd2;
                end
                go_idle();
              end
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    kcl_res_t seen;
    kcl_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.status     = out_chan.status;
      seen.user_slot  = out_chan.user_slot;
      seen.buzz_count = out_chan.buzz_count;
      seen.door_open  = out_chan.door_open;
      status_seen[seen.status]++;
      if (lock_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR @%0t: result with none pending: status=%0d slot=%0d buzz=%0d door=%0d",
                   $time, seen.status, seen.user_slot, seen.buzz_count, seen.door_open);
      end else begin
        want = lock_verdicts.pop_front();
        if (seen.status != want.status || seen.user_slot != want.user_slot ||
            seen.buzz_count != want.buzz_count || seen.door_open != want.door_open) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR @%0t: expected status=%0d slot=%0d buzz=%0d door=%0d, got %s",
                     $time, want.status, want.user_slot, want.buzz_count, want.door_open,
                     $sformatf("status=%0d slot=%0d buzz=%0d door=%0d", seen.status,
                               seen.user_slot, seen.buzz_count, seen.door_open));
        end
      end
    end
  end

  // result sink with random stall bursts
  initial begin : result_sink
    int unsigned hold;
    hold           = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && bursts_on && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 18);
      if (hold != 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("ERROR: timeout after %0d cycles, %0d results pending", cycles,
                 lock_verdicts.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one request: optional gap, then hold valid until accepted
  task automatic press_key(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.opcode   <= op;
    in_chan.key_code <= key;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    lock_verdicts.push_back(predict_verdict(op, key));
    requests_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (lock_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_ids(input logic [ID_W-1:0] ids [ID_REGS]);
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      // indexes past the ID registers get random data and must be ignored
      cfg_wdata <= (i < ID_REGS) ? ids[i] : ID_W'($urandom_range(0, 1023));
      @(posedge clk);
      if (i < ID_REGS && i < SLOTS) lk_ids[i] = ids[i];
    end
    cfg_we <= 1'b0;
    id_settings++;
  endtask

  // three keys whose weighted sum is the value
  function automatic bit spell_value(input int unsigned v, output logic [KEY_W-1:0] k0,
                                     output logic [KEY_W-1:0] k1, output logic [KEY_W-1:0] k2);
    for (int a = 0; a <= KEY_HASH; a++)
      for (int b = 0; b <= KEY_HASH; b++)
        for (int c = 0; c <= KEY_HASH; c++)
          if (key_weight(KEY_W'(a)) * 100 + key_weight(KEY_W'(b)) * 10 +
              key_weight(KEY_W'(c)) == v) begin
            k0 = KEY_W'(a);
            k1 = KEY_W'(b);
            k2 = KEY_W'(c);
            return 1'b1;
          end
    return 1'b0;
  endfunction

  // one three-key entry, now and then with a stray request mixed in
  task automatic key_entry(input int value);
    logic [KEY_W-1:0] k [3];
    logic [OPCODE_W-1:0] op;
    if (value < 0 || !spell_value(value, k[0], k[1], k[2]))
      for (int i = 0; i < 3; i++) k[i] = KEY_W'($urandom_range(0, KEY_HASH));
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        op = OPCODE_W'($urandom_range(0, 3));
        press_key(op, (op == OP_KEY) ? KEY_W'($urandom_range(12, 15))
                                     : KEY_W'($urandom_range(0, 15)));
      end
      press_key(OP_KEY, k[i]);
    end
  endtask

  function automatic int pick_id();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 999));
    return int'(lk_ids[$urandom_range(0, SLOTS - 1)]);
  endfunction

  function automatic int pick_code(input logic [SLOT_W-1:0] slot);
    if ($urandom_range(0, 6) == 0) return ANY_KEYS;
    return int'(lk_codes[slot]);
  endfunction

  function automatic int fresh_code();
    if ($urandom_range(0, 3) == 0) return ANY_KEYS;
    return int'($urandom_range(0, 999));
  endfunction

  // finish any open flow with random keys
  task automatic flush_flow();
    while (lk_mode != LOCK_IDLE) press_key(OP_KEY, KEY_W'($urandom_range(0, KEY_HASH)));
  endtask

  task automatic access_session();
    press_key(OP_KEY, KEY_STAR);
    key_entry(pick_id());
    if (lk_mode == LOCK_IDLE) return;
    key_entry(pick_code(lk_slot));
  endtask

  task automatic admin_session();
    press_key(OP_ADMIN, KEY_W'($urandom_range(0, 15)));
    key_entry(pick_code(SLOT_W'(0)));
    if (lk_mode == LOCK_IDLE) return;
    key_entry(pick_id());
    if (lk_mode == LOCK_IDLE) return;
    key_entry(pick_code(lk_slot));
    if (lk_mode == LOCK_IDLE) return;
    key_entry(fresh_code());
  endtask

  task automatic change_session();
    press_key(OP_CHANGE, KEY_W'($urandom_range(0, 15)));
    key_entry(pick_id());
    if (lk_mode == LOCK_IDLE) return;
    key_entry(pick_code(lk_slot));
    if (lk_mode == LOCK_IDLE) return;
    key_entry(fresh_code());
    // confirmation mostly repeats the first entry
    key_entry(($urandom_range(0, 6) == 0) ? fresh_code() : int'(lk_first_code));
  endtask

  task automatic run_sessions(input int unsigned count, input bit steady);
    int unsigned target;
    int unsigned pick;
    target = requests_sent + count;
    while (requests_sent < target) begin
      if (steady) bursts_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) bursts_on = !bursts_on;
      flush_flow();
      pick = $urandom_range(0, 19);
      if (pick < 9) access_session();
      else if (pick < 13) admin_session();
      else if (pick < 17) change_session();
      else begin
        repeat ($urandom_range(1, 6))
          press_key(OPCODE_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 15)));
      end
    end
    flush_flow();
  endtask

  // ---------------------------------------------------------------- tests

  // keys that idle must ignore
  task automatic test_idle_noise();
    press_key(OP_KEY, 4'd0);
    press_key(OP_KEY, KEY_HASH);
    press_key(2'd3, 4'd15);
  endtask

  // slot 4 opens with its code; ignored requests inside the flow; odd-key ID
  task automatic test_access_entry();
    press_key(OP_KEY, KEY_STAR);
    press_key(OP_KEY, 4'd1);
    press_key(OP_KEY, 4'd3);
    press_key(OP_KEY, 4'd2);
    press_key(OP_KEY, 4'd15);
    press_key(OP_CHANGE, 4'd0);
    press_key(OP_KEY, 4'd0);
    press_key(OP_KEY, 4'd7);
    press_key(OP_KEY, 4'd9);
    press_key(OP_KEY, KEY_STAR);
    press_key(OP_KEY, KEY_HASH);
    press_key(OP_KEY, KEY_STAR);
    press_key(OP_KEY, KEY_HASH);
  endtask

  // wrong admin code, unknown ID on a change request
  task automatic test_request_faults();
    press_key(OP_ADMIN, 4'd15);
    repeat (3) press_key(OP_KEY, 4'd9);
    press_key(OP_CHANGE, 4'd0);
    repeat (3) press_key(OP_KEY, 4'd9);
  endtask

  task automatic test_default_ids();
    run_sessions(150, 1'b0);
  endtask

  // zero, all ones and duplicate IDs
  task automatic test_id_extremes();
    logic [ID_W-1:0] ids [ID_REGS];
    settle();
    ids = '{10'd999, 10'd0, 10'd1023, 10'd999, 10'd500};
    program_ids(ids);
    bursts_on = 1'b1;
    run_sessions(150, 1'b0);
  endtask

  // random IDs, often repeating the previous one
  task automatic test_shuffled_ids();
    logic [ID_W-1:0] ids [ID_REGS];
    settle();
    for (int i = 0; i < ID_REGS; i++)
      ids[i] = (i > 0 && $urandom_range(0, 2) == 0) ? ids[i-1] : ID_W'($urandom_range(0, 999));
    program_ids(ids);
    run_sessions(120, 1'b0);
  endtask

  // back to reset IDs, no idling on either side
  task automatic test_steady_stream();
    logic [ID_W-1:0] ids [ID_REGS];
    settle();
    for (int i = 0; i < ID_REGS; i++) ids[i] = ID_RESET[i];
    program_ids(ids);
    run_sessions(80, 1'b1);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_chan.valid    = 1'b0;
    in_chan.opcode   = OP_KEY;
    in_chan.key_code = '0;
    bursts_on        = 1'b0;
    requests_sent    = 0;
    mismatches       = 0;
    id_settings      = 0;
    reset_lock_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    bursts_on = 1'b1;

    test_idle_noise();
    test_access_entry();
    test_request_faults();
    test_default_ids();
    test_id_extremes();
    test_shuffled_ids();
    test_steady_stream();
    settle();

    $display("Run: %0d requests over %0d ID settings; %0d doors opened, %0d codes stored",
             requests_sent, id_settings, status_seen[ST_DOOR_OPEN], status_seen[ST_STORED]);
    $display("Faults: %0d wrong id, %0d wrong code, %0d contact admin; %0d ignored",
             status_seen[ST_WRONG_ID], status_seen[ST_WRONG_CODE], status_seen[ST_CONTACT],
             status_seen[ST_IGNORED]);
    if (mismatches == 0 && lock_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, lock_verdicts.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
